// ===== src/wya_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wya_pkg;

    localparam int WINDOW_MAX_DEF = 256;

    localparam int TARGET_W   = 10;
    localparam int CFG_WIN_W  = 9;
    localparam int CFG_MIN_W  = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_OUT_W  = 9;

    localparam int PERMILLE_SCALE = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd2;

    localparam logic [TARGET_W-1:0]  TARGET_RST = 10'd0;
    localparam logic [CFG_WIN_W-1:0] WINDOW_RST = 9'd100;
    localparam logic [CFG_MIN_W-1:0] MIN_RST    = 9'd10;

endpackage

`default_nettype wire

// ===== src/wya_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wya_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/window_yield_alarm.sv =====
// Sliding-window yield monitor with a one-shot alarm latch.
// Input channel: one pass/fail round per request (i_round_ok), valid/ready.
// Output channel: one result per round, valid/ready. Fields are zero apart
// from o_evaluated = 0 when the target is zero or the window holds fewer
// than min_samples rounds.
// Config channel: index/data write, always ready. A write to a known index
// clears the alarm latch; a window write also empties the history.
// Write config only while no round is in flight.
// Pipeline: input register, then output register, which takes a round once free.
// Throughput: one round per cycle while results are taken, set by the combinational
// count update and the one read and one write port of the history RAM.
// Stall: the output register holds its result while i_out_ready is low; one
// further round is taken into the input register, after which o_in_ready
// drops until the result is taken.
// Reset: history, counts, latch and pipeline empty; target 0, window 100,
// min samples 10. No clearing pass: history entries are read only once
// written since the last clear.
`timescale 1ns / 1ps
`default_nettype none

module window_yield_alarm
    import wya_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_round_ok,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_evaluated,
    output logic [CNT_OUT_W-1:0]       o_sample_count,
    output logic [CNT_OUT_W-1:0]       o_pass_count,
    output logic                       o_below_target,
    output logic                       o_alarm_raised,
    output logic                       o_alarm_cleared,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (CW > CFG_WIN_W) ? CW : CFG_WIN_W;
    localparam int MW = CW + TARGET_W;
    localparam logic [EW-1:0] WMAX_E   = EW'(WINDOW_MAX);
    localparam logic [CW:0]   WMAX_X   = (CW + 1)'(WINDOW_MAX);
    localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_MAX - 1);

    logic [TARGET_W-1:0]  r_target;
    logic [CFG_WIN_W-1:0] r_win;
    logic [CFG_MIN_W-1:0] r_min;

    logic [AW-1:0] r_wr_pos;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_passes;
    logic          r_latched;

    logic r_in_vld;
    logic r_ok;
    logic r_byp;
    logic r_byp_bit;
    logic r_out_vld;

    logic [EW-1:0] win_e;
    logic [CW-1:0] w;
    logic          advance;
    logic          in_acc;
    logic [AW-1:0] n_wr_pos;
    logic [AW-1:0] pos_eff;
    logic [CW:0]   pos_x;
    logic [CW:0]   win_x;
    logic [CW:0]   old_x;
    logic [AW-1:0] rd_addr;
    logic          rd_data;
    logic          old_bit;
    logic          full;
    logic [CW-1:0] n_seen;
    logic [CW-1:0] n_passes;
    logic          judge;
    logic [MW-1:0] lhs;
    logic [MW-1:0] rhs;
    logic          below;
    logic          raised;
    logic          cleared;
    logic          n_latched;
    logic          cfg_acc;

    // effective window: zero reads as one, saturates at WINDOW_MAX
    always_comb begin
        if (r_win == '0) begin
            win_e = EW'(1);
        end else if (EW'(r_win) > WMAX_E) begin
            win_e = WMAX_E;
        end else begin
            win_e = EW'(r_win);
        end
        w = CW'(win_e);
    end

    assign advance     = r_in_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready  = ~r_in_vld | advance;
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign o_out_valid = r_out_vld;

    assign n_wr_pos = (r_wr_pos == POS_LAST) ? '0 : r_wr_pos + 1'b1;
    assign pos_eff  = advance ? n_wr_pos : r_wr_pos;

    // oldest entry for the request being accepted, as seen after the
    // request now leaving the input register has been written
    always_comb begin
        pos_x = (CW + 1)'(pos_eff);
        win_x = (CW + 1)'(w);
        if (pos_x >= win_x) begin
            old_x = pos_x - win_x;
        end else begin
            old_x = pos_x + WMAX_X - win_x;
        end
        rd_addr = AW'(old_x);
    end

    wya_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_wr_pos),
        .i_wdata (r_ok),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign old_bit = r_byp ? r_byp_bit : rd_data;

    always_comb begin
        full = (r_seen >= w);
        if (full) begin
            n_seen   = r_seen;
            n_passes = r_passes + CW'(r_ok) - CW'(old_bit);
        end else begin
            n_seen   = r_seen + 1'b1;
            n_passes = r_passes + CW'(r_ok);
        end
        judge   = (r_target != '0) && (EW'(n_seen) >= EW'(r_min));
        lhs     = MW'(PERMILLE_SCALE) * MW'(n_passes);
        rhs     = MW'(r_target) * MW'(n_seen);
        below   = (lhs < rhs);
        raised  = judge & below & ~r_latched;
        cleared = judge & ~below & r_latched;
        n_latched = r_latched;
        if (raised) begin
            n_latched = 1'b1;
        end else if (cleared) begin
            n_latched = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_RST;
            r_win     <= WINDOW_RST;
            r_min     <= MIN_RST;
            r_wr_pos  <= '0;
            r_seen    <= '0;
            r_passes  <= '0;
            r_latched <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_TARGET: begin
                    r_target  <= i_cfg_data[TARGET_W-1:0];
                    r_latched <= 1'b0;
                end
                CFG_WINDOW: begin
                    r_win     <= i_cfg_data[CFG_WIN_W-1:0];
                    r_latched <= 1'b0;
                    r_wr_pos  <= '0;
                    r_seen    <= '0;
                    r_passes  <= '0;
                end
                CFG_MIN: begin
                    r_min     <= i_cfg_data[CFG_MIN_W-1:0];
                    r_latched <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            r_wr_pos  <= n_wr_pos;
            r_seen    <= n_seen;
            r_passes  <= n_passes;
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload; bypass covers a read of the entry written on the same edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ok      <= i_round_ok;
            r_byp     <= advance && (rd_addr == r_wr_pos);
            r_byp_bit <= r_ok;
        end
        if (advance) begin
            o_evaluated     <= judge;
            o_sample_count  <= judge ? CNT_OUT_W'(n_seen) : '0;
            o_pass_count    <= judge ? CNT_OUT_W'(n_passes) : '0;
            o_below_target  <= judge & below;
            o_alarm_raised  <= raised;
            o_alarm_cleared <= cleared;
        end
    end

endmodule

`default_nettype wire

// ===== src/wya_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wya_checker
    import wya_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_evaluated,
    input wire logic [CNT_OUT_W-1:0]  o_sample_count,
    input wire logic [CNT_OUT_W-1:0]  o_pass_count,
    input wire logic                  o_below_target,
    input wire logic                  o_alarm_raised,
    input wire logic                  o_alarm_cleared
);

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evaluated) |->
            (o_sample_count == '0 && o_pass_count == '0 && !o_below_target
             && !o_alarm_raised && !o_alarm_cleared))
        else $error("unjudged result carries non-zero fields");

    a_alarm_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_alarm_raised && !o_below_target)
                         && !(o_alarm_cleared && o_below_target)))
        else $error("alarm edge disagrees with below_target");

    a_pass_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evaluated) |->
            (o_pass_count <= o_sample_count && o_sample_count != '0))
        else $error("pass count exceeds sample count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sample_count) && $stable(o_pass_count)
             && $stable(o_alarm_raised) && $stable(o_alarm_cleared)))
        else $error("stalled result changed");

endmodule

bind window_yield_alarm wya_checker u_wya_checker (.*);

`default_nettype wire

// ===== test/window_yield_alarm_check.sv =====
`timescale 1ns / 1ps

module window_yield_alarm_check
    import wya_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_round_ok,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_evaluated,
    input  wire logic [CNT_OUT_W-1:0]  i_sample_count,
    input  wire logic [CNT_OUT_W-1:0]  i_pass_count,
    input  wire logic                  i_below_target,
    input  wire logic                  i_alarm_raised,
    input  wire logic                  i_alarm_cleared,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_judged,
    output int                         o_raised,
    output int                         o_cleared
);

    localparam int PTR_W = $clog2(WINDOW_MAX_DEF);

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic                 evaluated;
        logic [CNT_OUT_W-1:0] samples;
        logic [CNT_OUT_W-1:0] passes;
        logic                 below;
        logic                 raised;
        logic                 cleared;
    } t_verdict;

    logic                 history [WINDOW_MAX_DEF];
    t_ptr                 wr_ptr;
    int                   seen;
    int                   passes;
    logic                 latched;
    logic [TARGET_W-1:0]  target;
    logic [CFG_WIN_W-1:0] window;
    logic [CFG_MIN_W-1:0] min_rounds;

    t_verdict verdict_q [$];
    int       fail_count = 0;
    int       results = 0;

    assign o_failures = fail_count;

    task automatic clear_window();
        for (int i = 0; i < WINDOW_MAX_DEF; i++) begin
            history[i] = 1'b0;
        end
        wr_ptr = '0;
        seen   = 0;
        passes = 0;
    endtask

    task automatic flag(input string what, input int exp_val, input int got_val);
        fail_count++;
        if (fail_count <= 10) begin
            $display("result %0d %s: expected %0d, got %0d", results, what, exp_val, got_val);
        end
    endtask

    function automatic t_verdict judge_round(input logic ok);
        int       eff;
        t_ptr     oldest;
        t_verdict v;
        v   = '0;
        eff = (window == 0) ? 1 : (window > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(window);
        if (seen < eff) begin
            seen++;
            passes += ok;
        end else begin
            oldest = wr_ptr - t_ptr'(eff);
            passes = passes + ok - history[oldest];
        end
        history[wr_ptr] = ok;
        wr_ptr++;
        if (target != 0 && seen >= min_rounds) begin
            v.evaluated = 1'b1;
            v.samples   = CNT_OUT_W'(seen);
            v.passes    = CNT_OUT_W'(passes);
            v.below     = PERMILLE_SCALE * passes < target * seen;
            if (v.below && !latched) begin
                v.raised = 1'b1;
                latched  = 1'b1;
            end else if (!v.below && latched) begin
                v.cleared = 1'b1;
                latched   = 1'b0;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict exp_v;
        t_verdict got_v;
        if (!i_rst_n) begin
            clear_window();
            latched    = 1'b0;
            target     = TARGET_RST;
            window     = WINDOW_RST;
            min_rounds = MIN_RST;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET: begin
                        target  = i_cfg_data[TARGET_W-1:0];
                        latched = 1'b0;
                    end
                    CFG_WINDOW: begin
                        window  = i_cfg_data[CFG_WIN_W-1:0];
                        clear_window();
                        latched = 1'b0;
                    end
                    CFG_MIN: begin
                        min_rounds = i_cfg_data[CFG_MIN_W-1:0];
                        latched    = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got_v = {i_evaluated, i_sample_count, i_pass_count,
                         i_below_target, i_alarm_raised, i_alarm_cleared};
                if (verdict_q.size() == 0) begin
                    flag("arrived with no request outstanding", 0, 1);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got_v.evaluated !== exp_v.evaluated)
                        flag("evaluated", exp_v.evaluated, got_v.evaluated);
                    if (got_v.samples !== exp_v.samples)
                        flag("sample_count", exp_v.samples, got_v.samples);
                    if (got_v.passes !== exp_v.passes)
                        flag("pass_count", exp_v.passes, got_v.passes);
                    if (got_v.below !== exp_v.below)
                        flag("below_target", exp_v.below, got_v.below);
                    if (got_v.raised !== exp_v.raised)
                        flag("alarm_raised", exp_v.raised, got_v.raised);
                    if (got_v.cleared !== exp_v.cleared)
                        flag("alarm_cleared", exp_v.cleared, got_v.cleared);
                    o_judged  += exp_v.evaluated;
                    o_raised  += exp_v.raised;
                    o_cleared += exp_v.cleared;
                end
                results++;
            end
            if (i_in_valid && i_in_ready) begin
                verdict_q.push_back(judge_round(i_round_ok));
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== test/window_yield_alarm_test.sv =====
`timescale 1ns / 1ps

module window_yield_alarm_test;
    import wya_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  round_ok = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                 in_ready;
    logic                 out_valid;
    logic                 evaluated;
    logic [CNT_OUT_W-1:0] sample_count;
    logic [CNT_OUT_W-1:0] pass_count;
    logic                 below_target;
    logic                 alarm_raised;
    logic                 alarm_cleared;
    logic                 cfg_ready;

    int failures, pending, judged, raised, cleared;
    int gap_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int rounds_sent = 0;
    int reg_writes = 0;

    window_yield_alarm u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_round_ok      (round_ok),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_evaluated     (evaluated),
        .o_sample_count  (sample_count),
        .o_pass_count    (pass_count),
        .o_below_target  (below_target),
        .o_alarm_raised  (alarm_raised),
        .o_alarm_cleared (alarm_cleared),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    window_yield_alarm_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_round_ok      (round_ok),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_evaluated     (evaluated),
        .i_sample_count  (sample_count),
        .i_pass_count    (pass_count),
        .i_below_target  (below_target),
        .i_alarm_raised  (alarm_raised),
        .i_alarm_cleared (alarm_cleared),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_judged        (judged),
        .o_raised        (raised),
        .o_cleared       (cleared)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("window_yield_alarm verification failed");
            $finish;
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 62; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 27; stall_pct = 27; end
        endcase
    endtask

    // valid is left high on return; a gap before the next request or a register write lowers it
    task automatic send_round(input logic ok);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        round_ok <= ok;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        rounds_sent++;
    endtask

    task automatic send_rounds(input int n, input int pass_pct);
        repeat (n) send_round($urandom_range(99) < pass_pct);
    endtask

    // block must be idle: drain outstanding results first
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    initial begin
        int pick, tgt, win, mn;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // target zero after reset: nothing judged
        send_round(1'b1);
        send_round(1'b0);
        write_reg(CFG_TARGET, 10'd500);
        send_round(1'b1);

        // window of zero acts as one, judged from the first round
        write_reg(CFG_WINDOW, 10'd0);
        write_reg(CFG_MIN, 10'd0);
        send_round(1'b0);
        send_round(1'b0);
        send_round(1'b1);
        send_round(1'b1);
        send_round(1'b0);

        // unknown index leaves the latch set
        write_reg(CFG_SPARE, 10'h3FF);
        send_round(1'b0);

        // target beyond full yield
        write_reg(CFG_TARGET, 10'h3FF);
        send_round(1'b1);

        // min samples above window
        write_reg(CFG_WINDOW, 10'd2);
        write_reg(CFG_MIN, 10'd5);
        send_round(1'b1);
        send_round(1'b1);
        send_round(1'b1);

        write_reg(CFG_MIN, 10'd2);
        write_reg(CFG_TARGET, 10'd1000);
        send_round(1'b1);
        send_round(1'b0);
        send_round(1'b0);
        send_round(1'b1);
        send_round(1'b1);

        write_reg(CFG_TARGET, 10'd1);
        write_reg(CFG_WINDOW, 10'd3);
        write_reg(CFG_MIN, 10'd1);
        send_round(1'b0);
        send_round(1'b0);
        send_round(1'b0);

        for (int p = 0; p < 8; p++) begin
            set_idle(p % 4);
            if (p == 5) begin
                // oversized window saturates; fill it with passes, then let it slide
                write_reg(CFG_TARGET, 10'd999);
                write_reg(CFG_WINDOW, 10'h3FF);
                write_reg(CFG_MIN, 10'd256);
                send_rounds(260, 100);
                send_rounds(20, 60);
            end else begin
                pick = $urandom_range(9);
                tgt = (pick == 0) ? 0 : (pick == 1) ? 1000 :
                      (pick == 2) ? $urandom_range(1001, 1023) : $urandom_range(1, 1000);
                win = ($urandom_range(3) == 0) ? $urandom_range(17, 511) : $urandom_range(0, 16);
                mn  = $urandom_range(0, ((win > 20) ? 20 : win) + 2);
                write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
                write_reg(CFG_WINDOW, {1'($urandom_range(1)), CFG_WIN_W'(win)});
                write_reg(CFG_MIN, {1'($urandom_range(1)), CFG_MIN_W'(mn)});
                if ($urandom_range(3) == 0) begin
                    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
                end
                send_rounds(30, $urandom_range(5, 95));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d rounds over %0d register writes, windows from 1 to 256 rounds",
                 rounds_sent, reg_writes);
        $display("%0d rounds judged, %0d alarms raised, %0d cleared", judged, raised, cleared);
        if (failures == 0 && pending == 0) begin
            $display("window_yield_alarm verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", failures, pending);
            $display("window_yield_alarm verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/wya_pkg.sv
src/wya_ram.sv
src/window_yield_alarm.sv
src/wya_checker.sv
test/window_yield_alarm_check.sv
test/window_yield_alarm_test.sv
